### design/argmax_majority_vote_filter_defines.svh
// assertion macros for the argmax majority vote filter rtl
`ifndef ARGMAX_MAJORITY_VOTE_FILTER_DEFINES_SVH
`define ARGMAX_MAJORITY_VOTE_FILTER_DEFINES_SVH

`ifndef SYNTH

`define AMVF_ASSERT(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("assertion failed: invariant");

`define AMVF_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

`define AMVF_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define AMVF_ASSERT(name, cond)
`define AMVF_ASSERT_IMP(name, ante, cons)
`define AMVF_ASSERT_NEXT(name, ante, cons)

`endif

`endif

### design/amvf_pkg.sv
// types and constants of the argmax majority vote filter
package amvf_pkg;

   localparam int MAX_WINDOW  = 16;
   localparam int MAX_CLASSES = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam int SCORE_W  = 16;
   localparam int LABEL_W  = 4;
   localparam int TIME_W   = 32;
   localparam int WIN_W    = 5;

   localparam int HIST_AW  = $clog2(MAX_WINDOW);
   localparam int FILL_W   = $clog2(MAX_WINDOW + 1);
   localparam int CLASS_AW = $clog2(MAX_CLASSES);
   localparam int IDX_W    = $clog2(MAX_CLASSES + 1);
   localparam int SUM_W    = SCORE_W + HIST_AW;
   localparam int DSTEP_W  = $clog2(SUM_W + 1);
   localparam int QPTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_AW = 2;
   localparam int CSR_DW = 32;

   localparam logic [CSR_AW-1:0] CSR_WINDOW_SIZE    = CSR_AW'(0);
   localparam logic [CSR_AW-1:0] CSR_TIMEOUT_ENABLE = CSR_AW'(1);
   localparam logic [CSR_AW-1:0] CSR_TIMEOUT_MS     = CSR_AW'(2);

   typedef struct packed {
      logic [SCORE_W-1:0] class_score;
      logic               frame_last;
      logic [TIME_W-1:0]  frame_time_ms;
   } req_type;

   typedef struct packed {
      logic [LABEL_W-1:0] class_label;
      logic [SCORE_W-1:0] class_confidence;
      logic               voted;
   } rsp_type;

   // finished argmax of one frame, handed from front to back
   typedef struct packed {
      logic [CLASS_AW-1:0] label;
      logic [SCORE_W-1:0]  score;
      logic [TIME_W-1:0]   time_ms;
   } frame_type;

   typedef struct packed {
      logic [WIN_W-1:0]  window_size;
      logic              timeout_enable;
      logic [TIME_W-1:0] timeout_ms;
   } cfg_type;

endpackage

### design/argmax_majority_vote_filter.sv
// argmax majority vote filter top level
//
// req side: one class score per word, push when full is low; frame_last marks
// the final score of a frame and frame_time_ms is sampled on that word.
// the front end takes one score word per cycle while full is low and hands
// each frame's argmax to a two-frame queue; full rises only while it is full.
// rsp side: one result word per frame, shown while empty is low, taken on pop.
// a raw result (voting off, window not yet full, or timeout clear) passes from
// the queue through the idle, check and emit states. a voted result walks the
// history entries (at most 15) one entry per cycle through the count table,
// then runs a bit-serial divide for the mean.
// csr side: write window_size, timeout_enable and timeout_ms by index, only
// while no frame is in flight.
// reset clears the argmax, the history fill, head and previous timestamp; the
// history contents are left as they are and are always written before use.
// a stalled receiver holds the result word; the back end then waits with the
// next result and the queue fills, after which full pushes back on the front.
module argmax_majority_vote_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   output logic                        req_full,
   input  amvf_pkg::req_type           req_data,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output amvf_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [amvf_pkg::CSR_AW-1:0] csr_index,
   input  logic [amvf_pkg::CSR_DW-1:0] csr_wdata
);

   amvf_pkg::cfg_type   cfg_ff, cfg_in;
   logic                accept;
   logic                frame_push;
   amvf_pkg::frame_type frame_wdata;
   amvf_pkg::frame_type frame_rdata;
   logic                frame_empty;
   logic                frame_pop;
   logic                rsp_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            amvf_pkg::CSR_WINDOW_SIZE: begin
               cfg_in.window_size = csr_wdata[amvf_pkg::WIN_W-1:0];
            end
            amvf_pkg::CSR_TIMEOUT_ENABLE: begin
               cfg_in.timeout_enable = csr_wdata[0];
            end
            amvf_pkg::CSR_TIMEOUT_MS: begin
               cfg_in.timeout_ms = csr_wdata[amvf_pkg::TIME_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
      accept    = req_push && !req_full;
      rsp_empty = !rsp_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   amvf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .frame_push (frame_push),
      .frame_data (frame_wdata)
   );

   amvf_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (frame_push),
      .wdata (frame_wdata),
      .full  (req_full),
      .pop   (frame_pop),
      .rdata (frame_rdata),
      .empty (frame_empty)
   );

   amvf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .frm_empty (frame_empty),
      .frm_data  (frame_rdata),
      .frm_pop   (frame_pop),
      .rsp_pop   (rsp_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### design/amvf_front.sv
// front end: running argmax over the scores of one frame
module amvf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  amvf_pkg::req_type   req_data,
   output logic                frame_push,
   output amvf_pkg::frame_type frame_data
);

   logic [amvf_pkg::SCORE_W-1:0]  best_score_ff, best_score_in;
   logic [amvf_pkg::CLASS_AW-1:0] best_label_ff, best_label_in;
   logic [amvf_pkg::IDX_W-1:0]    idx_ff, idx_in;

   logic                          in_range;
   logic                          take;
   logic [amvf_pkg::SCORE_W-1:0]  score_new;
   logic [amvf_pkg::CLASS_AW-1:0] label_new;

   always_comb begin
      in_range  = idx_ff < amvf_pkg::IDX_W'(amvf_pkg::MAX_CLASSES);
      // first score starts the best, later ones must be strictly greater
      take      = in_range && ((idx_ff == '0) || (req_data.class_score > best_score_ff));
      score_new = take ? req_data.class_score : best_score_ff;
      label_new = take ? idx_ff[amvf_pkg::CLASS_AW-1:0] : best_label_ff;

      best_score_in = best_score_ff;
      best_label_in = best_label_ff;
      idx_in        = idx_ff;
      if (accept) begin
         if (req_data.frame_last) begin
            best_score_in = '0;
            best_label_in = '0;
            idx_in        = '0;
         end else begin
            best_score_in = score_new;
            best_label_in = label_new;
            if (in_range) begin
               idx_in = idx_ff + amvf_pkg::IDX_W'(1);
            end
         end
      end

      frame_push         = accept && req_data.frame_last;
      frame_data.label   = label_new;
      frame_data.score   = score_new;
      frame_data.time_ms = req_data.frame_time_ms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff <= '0;
         best_label_ff <= '0;
         idx_ff        <= '0;
      end else begin
         best_score_ff <= best_score_in;
         best_label_ff <= best_label_in;
         idx_ff        <= idx_in;
      end
   end

endmodule

### design/amvf_queue.sv
// short frame queue between the front and back ends
module amvf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  amvf_pkg::frame_type wdata,
   output logic                full,
   input  logic                pop,
   output amvf_pkg::frame_type rdata,
   output logic                empty
);

   amvf_pkg::frame_type          mem_ff [amvf_pkg::QUEUE_DEPTH];
   logic [amvf_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [amvf_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [amvf_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   always_comb begin
      full    = count_ff == amvf_pkg::QCNT_W'(amvf_pkg::QUEUE_DEPTH);
      empty   = count_ff == '0;
      do_push = push && !full;
      do_pop  = pop && !empty;
      rdata   = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == amvf_pkg::QPTR_W'(amvf_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + amvf_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == amvf_pkg::QPTR_W'(amvf_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + amvf_pkg::QPTR_W'(1);
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + amvf_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - amvf_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/amvf_div.sv
// restoring divider, one quotient bit per cycle, for the vote mean
module amvf_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [amvf_pkg::SUM_W-1:0]    dividend,
   input  logic [amvf_pkg::FILL_W-1:0]   divisor,
   output logic                          done,
   output logic [amvf_pkg::SUM_W-1:0]    quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [amvf_pkg::DSTEP_W-1:0]  step_ff, step_in;
   logic [amvf_pkg::FILL_W-1:0]   rem_ff, rem_in;
   logic [amvf_pkg::FILL_W-1:0]   dvs_ff, dvs_in;
   logic [amvf_pkg::SUM_W-1:0]    quo_ff, quo_in;
   logic [amvf_pkg::FILL_W:0]     rem_sh;
   logic                          fits;

   always_comb begin
      // shift in the next dividend bit, subtract when the divisor fits
      rem_sh = {rem_ff, quo_ff[amvf_pkg::SUM_W-1]};
      fits   = rem_sh >= {1'b0, dvs_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = amvf_pkg::DSTEP_W'(amvf_pkg::SUM_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? amvf_pkg::FILL_W'(rem_sh - {1'b0, dvs_ff}) :
                          amvf_pkg::FILL_W'(rem_sh);
         quo_in  = {quo_ff[amvf_pkg::SUM_W-2:0], fits};
         step_in = step_ff - amvf_pkg::DSTEP_W'(1);
         if (step_ff == amvf_pkg::DSTEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      done     = done_ff;
      quotient = quo_ff;
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

### design/amvf_back.sv
// back end: vote history, timeout, majority walk and result register
`include "argmax_majority_vote_filter_defines.svh"

module amvf_back (
   input  logic                clock,
   input  logic                reset,
   input  amvf_pkg::cfg_type   cfg,
   input  logic                frm_empty,
   input  amvf_pkg::frame_type frm_data,
   output logic                frm_pop,
   input  logic                rsp_pop,
   output logic                rsp_valid,
   output amvf_pkg::rsp_type   rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type                     state_ff, state_in;
   amvf_pkg::frame_type           rec_ff, rec_in;
   logic [amvf_pkg::TIME_W:0]     diff_ff, diff_in;
   logic [amvf_pkg::TIME_W-1:0]   prev_ff, prev_in;
   logic [amvf_pkg::FILL_W-1:0]   fill_ff, fill_in;
   logic [amvf_pkg::HIST_AW-1:0]  head_ff, head_in;
   logic [amvf_pkg::FILL_W-1:0]   walk_ff, walk_in;

   logic [amvf_pkg::CLASS_AW-1:0] hist_label_ff [amvf_pkg::MAX_WINDOW];
   logic [amvf_pkg::CLASS_AW-1:0] hist_label_in [amvf_pkg::MAX_WINDOW];
   logic [amvf_pkg::SCORE_W-1:0]  hist_score_ff [amvf_pkg::MAX_WINDOW];
   logic [amvf_pkg::SCORE_W-1:0]  hist_score_in [amvf_pkg::MAX_WINDOW];
   logic [amvf_pkg::FILL_W-1:0]   cnt_ff [amvf_pkg::MAX_CLASSES];
   logic [amvf_pkg::FILL_W-1:0]   cnt_in [amvf_pkg::MAX_CLASSES];
   logic [amvf_pkg::SUM_W-1:0]    sum_ff [amvf_pkg::MAX_CLASSES];
   logic [amvf_pkg::SUM_W-1:0]    sum_in [amvf_pkg::MAX_CLASSES];

   logic [amvf_pkg::CLASS_AW-1:0] top_label_ff, top_label_in;
   logic [amvf_pkg::FILL_W-1:0]   top_count_ff, top_count_in;
   logic [amvf_pkg::SUM_W-1:0]    top_sum_ff, top_sum_in;
   amvf_pkg::rsp_type             res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   amvf_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic [amvf_pkg::FILL_W-1:0]   eff;
   logic [amvf_pkg::FILL_W-1:0]   fill_push;
   logic [amvf_pkg::HIST_AW-1:0]  slot_push;
   logic [amvf_pkg::HIST_AW-1:0]  slot_walk;
   logic [amvf_pkg::CLASS_AW-1:0] walk_label;
   logic [amvf_pkg::FILL_W-1:0]   cnt_new;
   logic [amvf_pkg::SUM_W-1:0]    sum_new;
   logic                          timed_out;
   logic                          div_start;
   logic                          div_done;
   logic [amvf_pkg::SUM_W-1:0]    div_quo;

   amvf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (top_sum_ff),
      .divisor  (top_count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      eff = (int'(cfg.window_size) > amvf_pkg::MAX_WINDOW) ?
            amvf_pkg::FILL_W'(amvf_pkg::MAX_WINDOW) : amvf_pkg::FILL_W'(cfg.window_size);
      slot_push = head_ff + fill_ff[amvf_pkg::HIST_AW-1:0];
      fill_push = (fill_ff < amvf_pkg::FILL_W'(amvf_pkg::MAX_WINDOW)) ?
                  fill_ff + amvf_pkg::FILL_W'(1) : fill_ff;
      // no earlier frame, or a timestamp going backwards, never clears
      timed_out = cfg.timeout_enable && (prev_ff != '0) && !diff_ff[amvf_pkg::TIME_W] &&
                  (diff_ff[amvf_pkg::TIME_W-1:0] >= cfg.timeout_ms);

      slot_walk  = head_ff + walk_ff[amvf_pkg::HIST_AW-1:0];
      walk_label = hist_label_ff[slot_walk];
      cnt_new    = cnt_ff[walk_label] + amvf_pkg::FILL_W'(1);
      sum_new    = sum_ff[walk_label] + amvf_pkg::SUM_W'(hist_score_ff[slot_walk]);

      state_in      = state_ff;
      rec_in        = rec_ff;
      diff_in       = diff_ff;
      prev_in       = prev_ff;
      fill_in       = fill_ff;
      head_in       = head_ff;
      walk_in       = walk_ff;
      hist_label_in = hist_label_ff;
      hist_score_in = hist_score_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      top_label_in  = top_label_ff;
      top_count_in  = top_count_ff;
      top_sum_in    = top_sum_ff;
      res_in        = res_ff;
      frm_pop       = 1'b0;
      div_start     = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!frm_empty) begin
               frm_pop  = 1'b1;
               rec_in   = frm_data;
               diff_in  = {1'b0, frm_data.time_ms} - {1'b0, prev_ff};
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            res_in.class_label      = amvf_pkg::LABEL_W'(rec_ff.label);
            res_in.class_confidence = rec_ff.score;
            res_in.voted            = 1'b0;
            if (cfg.window_size <= amvf_pkg::WIN_W'(1)) begin
               state_in = ST_EMIT;
            end else begin
               if (fill_ff < amvf_pkg::FILL_W'(amvf_pkg::MAX_WINDOW)) begin
                  hist_label_in[slot_push] = rec_ff.label;
                  hist_score_in[slot_push] = rec_ff.score;
               end
               prev_in = rec_ff.time_ms;
               if (timed_out) begin
                  // clear drops the word just pushed as well
                  fill_in  = '0;
                  head_in  = '0;
                  state_in = ST_EMIT;
               end else if (fill_push < eff) begin
                  fill_in  = fill_push;
                  state_in = ST_EMIT;
               end else begin
                  head_in      = head_ff + amvf_pkg::HIST_AW'(1);
                  fill_in      = fill_push - amvf_pkg::FILL_W'(1);
                  walk_in      = '0;
                  top_label_in = '0;
                  top_count_in = '0;
                  top_sum_in   = '0;
                  for (int i = 0; i < amvf_pkg::MAX_CLASSES; i++) begin
                     cnt_in[i] = '0;
                     sum_in[i] = '0;
                  end
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            cnt_in[walk_label] = cnt_new;
            sum_in[walk_label] = sum_new;
            // oldest first, the first label to reach a new top count wins
            if (cnt_new > top_count_ff) begin
               top_label_in = walk_label;
               top_count_in = cnt_new;
               top_sum_in   = sum_new;
            end
            walk_in = walk_ff + amvf_pkg::FILL_W'(1);
            if (walk_ff + amvf_pkg::FILL_W'(1) == fill_ff) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               res_in.class_label      = amvf_pkg::LABEL_W'(top_label_ff);
               res_in.class_confidence = div_quo[amvf_pkg::SCORE_W-1:0];
               res_in.voted            = 1'b1;
               state_in                = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      rec_ff        <= rec_in;
      diff_ff       <= diff_in;
      walk_ff       <= walk_in;
      hist_label_ff <= hist_label_in;
      hist_score_ff <= hist_score_in;
      cnt_ff        <= cnt_in;
      sum_ff        <= sum_in;
      top_label_ff  <= top_label_in;
      top_count_ff  <= top_count_in;
      top_sum_ff    <= top_sum_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         fill_ff      <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `AMVF_ASSERT(a_fill_bound, fill_ff <= amvf_pkg::FILL_W'(amvf_pkg::MAX_WINDOW))
   `AMVF_ASSERT_IMP(a_div_nonzero, state_ff == ST_LAUNCH, top_count_ff != '0)
   `AMVF_ASSERT_IMP(a_walk_range, state_ff == ST_WALK, walk_ff < fill_ff)
   `AMVF_ASSERT_IMP(a_pop_nonempty, frm_pop, !frm_empty)

endmodule
